FILE: src/rpss_pkg.sv
`default_nettype none

package rpss_pkg;

  // Pad count that the top level uses unless told otherwise.
  localparam int DEFAULT_NUM_PADS = 9;

  // Field widths fixed by the interface.
  localparam int ADC_W      = 10;
  localparam int PAD_W      = 4;
  localparam int PRESSURE_W = 13;
  localparam int POS_W      = 11;
  localparam int TERM_W     = 11;
  localparam int LIMIT_W    = 13;
  localparam int THRESH_W   = 12;
  localparam int CFG_IDX_W  = 2;

  // Opcodes of the input word.
  localparam logic [1:0] OP_ADC      = 2'd0;
  localparam logic [1:0] OP_CONTINUE = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_THRESHOLD = 2'd2;

  localparam logic [LIMIT_W-1:0]  PRESSURE_LIMIT_RST    = 13'd4096;
  localparam logic [THRESH_W-1:0] PRESS_THRESHOLD_RST   = 12'd100;
  localparam logic [THRESH_W-1:0] RELEASE_THRESHOLD_RST = 12'd50;

  // Full scale of a conversion, and the largest pressure sum kept.
  localparam logic [POS_W-1:0]      ADC_FULL_SCALE = 11'd1023;
  localparam logic [PRESSURE_W-1:0] PRESSURE_SAT   = 13'd4095;

  // Plate drive codes.
  localparam logic [1:0] SETUP_PRESS_A = 2'd0;
  localparam logic [1:0] SETUP_PRESS_B = 2'd1;
  localparam logic [1:0] SETUP_X       = 2'd2;
  localparam logic [1:0] SETUP_Y       = 2'd3;

  // Sampled pin codes.
  localparam logic [1:0] PIN_X_PLUS  = 2'd0;
  localparam logic [1:0] PIN_Y_PLUS  = 2'd1;
  localparam logic [1:0] PIN_Y_MINUS = 2'd2;
  localparam logic [1:0] PIN_X_MINUS = 2'd3;

  // One stored entry per pad. All ones in a field means never read.
  typedef struct packed {
    logic [PRESSURE_W-1:0] pressure;
    logic [POS_W-1:0]      x;
    logic [POS_W-1:0]      y;
  } entry_t;

  localparam entry_t ENTRY_UNREAD = '{pressure: '1, x: '1, y: '1};

  function automatic logic [1:0] setup_of_step(input logic [2:0] step);
    logic [1:0] s;
    case (step)
      3'd0, 3'd1: s = SETUP_PRESS_A;
      3'd2, 3'd3: s = SETUP_PRESS_B;
      3'd4:       s = SETUP_X;
      3'd5:       s = SETUP_Y;
      default:    s = SETUP_PRESS_A;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] pin_of_step(input logic [2:0] step);
    logic [1:0] p;
    case (step)
      3'd0:    p = PIN_X_PLUS;
      3'd1:    p = PIN_Y_PLUS;
      3'd2:    p = PIN_Y_MINUS;
      3'd3:    p = PIN_X_MINUS;
      3'd4:    p = PIN_Y_PLUS;
      3'd5:    p = PIN_X_PLUS;
      default: p = PIN_X_PLUS;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: src/rpss_pad_store.sv
`default_nettype none

module rpss_pad_store #(
  parameter int NUM_PADS = rpss_pkg::DEFAULT_NUM_PADS,
  parameter int AW       = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire rpss_pkg::entry_t wr_data,
  output rpss_pkg::entry_t     rd_data
);

  rpss_pkg::entry_t entry_mem_r [NUM_PADS];
  rpss_pkg::entry_t mem_q_r;
  rpss_pkg::entry_t fwd_data_r;
  logic [NUM_PADS-1:0] valid_r;
  logic rd_valid_r;
  logic fwd_hit_r;

  // Synchronous memory; the read data is registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= entry_mem_r[rd_addr];
    end
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  // A write landing on the entry being read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
        fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (fwd_hit_r) begin
      rd_data = fwd_data_r;
    end else if (rd_valid_r) begin
      rd_data = mem_q_r;
    end else begin
      rd_data = rpss_pkg::ENTRY_UNREAD;
    end
  end

endmodule

`default_nettype wire

FILE: src/resistive_pad_scan_sequencer.sv
`default_nettype none

// Scan sequencer for a multiplexed set of four-wire resistive pads. Each word
// on the input channel is an ADC completion, a continue command or a pad query,
// and each produces exactly one result word carrying the conversion start
// request, the plate drive, the sampled pin, the selected pad and the scan done
// flag as they stand after the word, plus the query results (zero for words
// that are not queries). The block takes one input word per clock cycle unless
// the result channel stalls. The per-pad pressure, X and Y values live in a
// single synchronous memory; a word is accepted while the memory is read, then
// its entry is modified and written back in the memory stage while the result
// is registered. A word that touches the entry written back by its predecessor
// in that same edge sees the forwarded value, so there is no interlock. Unread
// pads report minus one from flip-flop valid bits that reset clears at once, so
// no clearing pass is needed after reset.
// Configuration writes are always taken and must only arrive while the block
// is idle.

module resistive_pad_scan_sequencer #(
  parameter int NUM_PADS = rpss_pkg::DEFAULT_NUM_PADS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           in_opcode,
  input  wire logic [rpss_pkg::ADC_W-1:0]           in_adc_value,
  input  wire logic [rpss_pkg::PAD_W-1:0]           in_pad,
  input  wire logic                                 in_pad_pressed,
  // Result channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_start_conversion,
  output logic [1:0]                                out_plate_setup,
  output logic [1:0]                                out_adc_pin,
  output logic [rpss_pkg::PAD_W-1:0]                out_mux_pad,
  output logic                                      out_scan_done,
  output logic signed [rpss_pkg::PRESSURE_W-1:0]    out_pressure,
  output logic signed [rpss_pkg::POS_W-1:0]         out_x_pos,
  output logic signed [rpss_pkg::POS_W-1:0]         out_y_pos,
  // Configuration channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rpss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rpss_pkg::LIMIT_W-1:0]         cfg_data
);

  // Pad counter holds NUM_PADS itself when the scan is stopped.
  localparam int PCW = $clog2(NUM_PADS + 1);
  localparam int AW  = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

  // Reading steps of one pad.
  typedef enum logic [2:0] {
    STEP_A_FIRST  = 3'd0,
    STEP_A_SECOND = 3'd1,
    STEP_B_FIRST  = 3'd2,
    STEP_B_SECOND = 3'd3,
    STEP_X        = 3'd4,
    STEP_Y        = 3'd5
  } step_t;

  // What the memory stage does with the entry it has read.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SET_PRESSURE,
    ACT_ADD_PRESSURE,
    ACT_SET_X,
    ACT_SET_Y,
    ACT_QUERY,
    ACT_QUERY_RANGE
  } act_t;

  // Status of the scan after a word, carried down the pipe.
  typedef struct packed {
    logic                       start;
    logic [1:0]                 setup;
    logic [1:0]                 pin;
    logic [rpss_pkg::PAD_W-1:0] mux_pad;
    logic                       done;
  } status_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [rpss_pkg::LIMIT_W-1:0]  limit_r;
  logic [rpss_pkg::THRESH_W-1:0] press_r;
  logic [rpss_pkg::THRESH_W-1:0] release_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= rpss_pkg::PRESSURE_LIMIT_RST;
      press_r   <= rpss_pkg::PRESS_THRESHOLD_RST;
      release_r <= rpss_pkg::RELEASE_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rpss_pkg::CFG_PRESSURE_LIMIT:    limit_r   <= cfg_data;
        rpss_pkg::CFG_PRESS_THRESHOLD:   press_r   <= cfg_data[rpss_pkg::THRESH_W-1:0];
        rpss_pkg::CFG_RELEASE_THRESHOLD: release_r <= cfg_data[rpss_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic s1_valid_r;
  logic s1_adv;
  logic out_valid_r;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Accept stage: scan sequencing and memory read
  // ---------------------------------------------------------------------------
  logic                        discard_r, discard_nxt;
  step_t                       step_r, step_nxt;
  logic [PCW-1:0]              active_pad_r, active_pad_nxt;
  logic [rpss_pkg::ADC_W-1:0]  first_r, first_nxt;
  logic                        stopped;
  logic                        stopped_nxt;
  act_t                        act;
  logic [AW-1:0]               rd_addr;
  status_t                     status;
  logic [rpss_pkg::TERM_W-1:0] term;

  assign stopped     = active_pad_r >= PCW'(NUM_PADS);
  assign stopped_nxt = active_pad_nxt >= PCW'(NUM_PADS);

  // 1023 minus (second reading minus first reading); always within 0 to 2046.
  assign term = rpss_pkg::ADC_FULL_SCALE - {1'b0, in_adc_value} + {1'b0, first_r};

  always_comb begin
    discard_nxt    = discard_r;
    step_nxt       = step_r;
    active_pad_nxt = active_pad_r;
    first_nxt      = first_r;
    act            = ACT_NONE;
    rd_addr        = active_pad_r[AW-1:0];
    status.start   = 1'b0;

    case (in_opcode)
      rpss_pkg::OP_ADC: begin
        if (!stopped) begin
          if (discard_r) begin
            // The settling conversion is thrown away.
            discard_nxt  = 1'b0;
            status.start = 1'b1;
          end else begin
            case (step_r)
              STEP_A_FIRST: begin
                first_nxt = in_adc_value;
                step_nxt  = STEP_A_SECOND;
              end
              STEP_B_FIRST: begin
                first_nxt = in_adc_value;
                step_nxt  = STEP_B_SECOND;
              end
              STEP_A_SECOND: begin
                act      = ACT_SET_PRESSURE;
                step_nxt = STEP_B_FIRST;
              end
              STEP_B_SECOND: begin
                act      = ACT_ADD_PRESSURE;
                step_nxt = STEP_X;
              end
              STEP_X: begin
                act      = ACT_SET_X;
                step_nxt = STEP_Y;
              end
              default: begin
                act            = ACT_SET_Y;
                step_nxt       = STEP_A_FIRST;
                active_pad_nxt = active_pad_r + PCW'(1);
              end
            endcase
            // Finishing the last pad stops the scan with discard left clear.
            if (active_pad_nxt < PCW'(NUM_PADS)) begin
              discard_nxt  = 1'b1;
              status.start = 1'b1;
            end
          end
        end
      end
      rpss_pkg::OP_CONTINUE: begin
        active_pad_nxt = '0;
        status.start   = 1'b1;
      end
      rpss_pkg::OP_QUERY: begin
        if ({1'b0, in_pad} < (rpss_pkg::PAD_W + 1)'(NUM_PADS)) begin
          act     = ACT_QUERY;
          rd_addr = in_pad[AW-1:0];
        end else begin
          act = ACT_QUERY_RANGE;
        end
      end
      default: ;
    endcase

    status.setup   = rpss_pkg::setup_of_step(step_nxt);
    status.pin     = rpss_pkg::pin_of_step(step_nxt);
    status.mux_pad = stopped_nxt ? '0 : rpss_pkg::PAD_W'(active_pad_nxt);
    status.done    = stopped_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discard_r    <= 1'b1;
      step_r       <= STEP_A_FIRST;
      active_pad_r <= '0;
      first_r      <= '0;
    end else if (in_fire) begin
      discard_r    <= discard_nxt;
      step_r       <= step_nxt;
      active_pad_r <= active_pad_nxt;
      first_r      <= first_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Memory stage: modify the entry, write it back, form the result
  // ---------------------------------------------------------------------------
  act_t                        s1_act_r;
  logic [AW-1:0]               s1_addr_r;
  logic [rpss_pkg::TERM_W-1:0] s1_term_r;
  logic [rpss_pkg::ADC_W-1:0]  s1_adc_r;
  logic                        s1_held_r;
  status_t                     s1_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_act_r   <= ACT_NONE;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
      s1_act_r   <= act;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r   <= rd_addr;
      s1_term_r   <= term;
      s1_adc_r    <= in_adc_value;
      s1_held_r   <= in_pad_pressed;
      s1_status_r <= status;
    end
  end

  rpss_pkg::entry_t old_entry;
  rpss_pkg::entry_t new_entry;
  logic             wr_en;
  logic             wr_req;

  rpss_pad_store #(
    .NUM_PADS (NUM_PADS),
    .AW       (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (new_entry),
    .rd_data (old_entry)
  );

  assign wr_en = s1_adv && wr_req;

  logic [rpss_pkg::PRESSURE_W:0]   sum;
  logic [rpss_pkg::LIMIT_W-1:0]    lim;
  logic [rpss_pkg::PRESSURE_W-1:0] clamped;
  logic [rpss_pkg::PRESSURE_W-1:0] pr;
  logic [rpss_pkg::POS_W-1:0]      xp;
  logic [rpss_pkg::POS_W-1:0]      yp;

  // The sum can only be negative when a pad that was never read picks up
  // the second half of a pressure measurement, and then it is minus one.
  assign sum = {old_entry.pressure[rpss_pkg::PRESSURE_W-1], old_entry.pressure}
             + (rpss_pkg::PRESSURE_W + 1)'(s1_term_r);

  // A zero limit acts as a limit of one.
  assign lim = (limit_r == '0) ? rpss_pkg::LIMIT_W'(1) : limit_r;

  always_comb begin
    new_entry = old_entry;
    wr_req    = 1'b0;
    pr        = '0;
    xp        = '0;
    yp        = '0;
    clamped   = old_entry.pressure;

    case (s1_act_r)
      ACT_SET_PRESSURE: begin
        new_entry.pressure = rpss_pkg::PRESSURE_W'(s1_term_r);
        wr_req             = 1'b1;
      end
      ACT_ADD_PRESSURE: begin
        if (!sum[rpss_pkg::PRESSURE_W] && sum[rpss_pkg::PRESSURE_W-1]) begin
          new_entry.pressure = rpss_pkg::PRESSURE_SAT;
        end else begin
          new_entry.pressure = sum[rpss_pkg::PRESSURE_W-1:0];
        end
        wr_req = 1'b1;
      end
      ACT_SET_X: begin
        new_entry.x = {1'b0, s1_adc_r};
        wr_req      = 1'b1;
      end
      ACT_SET_Y: begin
        new_entry.y = {1'b0, s1_adc_r};
        wr_req      = 1'b1;
      end
      ACT_QUERY: begin
        if (old_entry.pressure == '1) begin
          pr = '1;
        end else begin
          // The clamp is written back, so later queries see it.
          if (old_entry.pressure >= lim) begin
            clamped            = lim - rpss_pkg::LIMIT_W'(1);
            new_entry.pressure = clamped;
            wr_req             = 1'b1;
          end
          // Hysteresis: a held pad keeps reporting until it drops below
          // the release threshold.
          if (clamped < {1'b0, press_r}) begin
            if (!s1_held_r || (clamped < {1'b0, release_r})) begin
              pr = '0;
            end else begin
              pr = clamped;
            end
          end else begin
            pr = clamped - {1'b0, press_r};
          end
        end
        xp = (old_entry.x == '1) ? '1 : rpss_pkg::ADC_FULL_SCALE - old_entry.x;
        yp = old_entry.y;
      end
      ACT_QUERY_RANGE: begin
        pr = '1;
        xp = '1;
        yp = '1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_start_conversion <= s1_status_r.start;
      out_plate_setup      <= s1_status_r.setup;
      out_adc_pin          <= s1_status_r.pin;
      out_mux_pad          <= s1_status_r.mux_pad;
      out_scan_done        <= s1_status_r.done;
      out_pressure         <= pr;
      out_x_pos            <= xp;
      out_y_pos            <= yp;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pad_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_pad_r <= PCW'(NUM_PADS))
    else $error("pad counter ran past the number of pads");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while the memory stage is stalled");

  a_continue_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_opcode == rpss_pkg::OP_CONTINUE)) |=> (active_pad_r == '0))
    else $error("continue did not return the scan to the first pad");

  a_start_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_start_conversion) |-> !out_scan_done)
    else $error("conversion requested while the scan is stopped");

  a_write_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_valid_r && out_free))
    else $error("memory written without a word leaving the memory stage");

endmodule

`default_nettype wire
